### hw/rtl/qpg_pkg.sv
// Shared types and constants for the projected gravity pipeline.
// No dependencies.
package qpg_pkg;

  localparam int CompWidth = 24;
  localparam int OutWidth  = 16;
  localparam int ProdWidth = 2 * CompWidth;
  // sum of four squares, unsigned, and the bound on every numerator magnitude
  localparam int SumWidth  = ProdWidth + 2;

  typedef struct packed {
    logic signed [CompWidth-1:0] quat_w;
    logic signed [CompWidth-1:0] quat_x;
    logic signed [CompWidth-1:0] quat_y;
    logic signed [CompWidth-1:0] quat_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] grav_x;
    logic signed [OutWidth-1:0] grav_y;
    logic signed [OutWidth-1:0] grav_z;
    logic                       bad_quat;
  } grav_out_t;

  // control that travels beside the three lanes
  typedef struct packed {
    logic       valid;
    logic       bad;
    logic [2:0] neg;
  } lane_ctl_t;

endpackage

### hw/rtl/qpg_prod.sv
// Front end: products, sum of squares, numerator signs and magnitudes.
// Depends on qpg_pkg.
module qpg_prod (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  qpg_pkg::quat_in_t                   quat,
  output qpg_pkg::lane_ctl_t                  ctl,
  output logic [qpg_pkg::SumWidth-1:0]        sum_sq,
  output logic [2:0][qpg_pkg::SumWidth-1:0]   mag
);
  import qpg_pkg::*;

  localparam int NW = SumWidth + 1;

  logic                        p_valid;
  logic signed [ProdWidth-1:0] p_ww, p_xx, p_yy, p_zz, p_wy, p_xz, p_wx, p_yz;
  logic signed [NW-1:0]        s_full, nx, ny, nz;
  logic [NW-1:0]               ax, ay, az;

  // stage 1: eight products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= in_valid;
    end
    p_ww <= quat.quat_w * quat.quat_w;
    p_xx <= quat.quat_x * quat.quat_x;
    p_yy <= quat.quat_y * quat.quat_y;
    p_zz <= quat.quat_z * quat.quat_z;
    p_wy <= quat.quat_w * quat.quat_y;
    p_xz <= quat.quat_x * quat.quat_z;
    p_wx <= quat.quat_w * quat.quat_x;
    p_yz <= quat.quat_y * quat.quat_z;
  end

  always_comb begin
    s_full = NW'(p_ww) + NW'(p_xx) + NW'(p_yy) + NW'(p_zz);
    nx = (NW'(p_wy) - NW'(p_xz)) <<< 1;
    ny = -((NW'(p_wx) + NW'(p_yz)) <<< 1);
    nz = NW'(p_xx) + NW'(p_yy) - NW'(p_ww) - NW'(p_zz);
    ax = nx[NW-1] ? NW'(-nx) : NW'(nx);
    ay = ny[NW-1] ? NW'(-ny) : NW'(ny);
    az = nz[NW-1] ? NW'(-nz) : NW'(nz);
  end

  // stage 2: sum and numerators, magnitude bounded by the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= p_valid;
    end
    ctl.bad <= (s_full == '0);
    ctl.neg <= {nz[NW-1], ny[NW-1], nx[NW-1]};
    sum_sq  <= s_full[SumWidth-1:0];
    mag     <= {az[SumWidth-1:0], ay[SumWidth-1:0], ax[SumWidth-1:0]};
  end

endmodule

### hw/rtl/qpg_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage,
// then rounding, saturation and sign. Depends on qpg_pkg.
module qpg_div #(
  parameter int FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  qpg_pkg::lane_ctl_t                 in_ctl,
  input  logic [qpg_pkg::SumWidth-1:0]       sum_sq,
  input  logic [2:0][qpg_pkg::SumWidth-1:0]  mag,
  output logic                               out_valid,
  output qpg_pkg::grav_out_t                 grav
);
  import qpg_pkg::*;

  localparam int SW = SumWidth;
  localparam int QW = FRAC_BITS + 2;
  localparam int NS = FRAC_BITS + 1;  // integer bit plus fraction bits

  lane_ctl_t                    ctl [0:NS];
  logic [NS-1:0][SW-1:0]        sv;
  logic [NS-1:0][2:0][SW-1:0]   rem;
  logic [NS:0][2:0][QW-1:0]     quo;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    lane_ctl_t           c_in;
    logic [SW-1:0]       s_in;
    logic [2:0][SW:0]    rr;
    logic [2:0][QW-1:0]  q_in;
    logic [2:0]          ge;
    logic [2:0][SW:0]    rn;
    logic [2:0][QW-1:0]  qn;
    if (k == 0) begin : g_src
      // stage 0: integer bit, no shift
      assign c_in = in_ctl;
      assign s_in = sum_sq;
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rr[j]   = {1'b0, mag[j]};
        assign q_in[j] = '0;
      end
    end else begin : g_src
      assign c_in = ctl[k-1];
      assign s_in = sv[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rr[j]   = {rem[k-1][j], 1'b0};
        assign q_in[j] = quo[k-1][j];
      end
    end
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        ge[j] = (rr[j] >= {1'b0, s_in});
        rn[j] = ge[j] ? rr[j] - {1'b0, s_in} : rr[j];
        qn[j] = {q_in[j][QW-2:0], ge[j]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k].valid <= 1'b0;
      end else begin
        ctl[k].valid <= c_in.valid;
      end
      ctl[k].bad <= c_in.bad;
      ctl[k].neg <= c_in.neg;
      sv[k]      <= s_in;
      for (int j = 0; j < 3; j++) begin
        rem[k][j] <= rn[j][SW-1:0];
        quo[k][j] <= qn[j];
      end
    end
  end

  // rounding stage: half up on the magnitude
  logic [2:0] rnd;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rnd[j] = ({rem[NS-1][j], 1'b0} >= {1'b0, sv[NS-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[NS].valid <= 1'b0;
    end else begin
      ctl[NS].valid <= ctl[NS-1].valid;
    end
    ctl[NS].bad <= ctl[NS-1].bad;
    ctl[NS].neg <= ctl[NS-1].neg;
    for (int j = 0; j < 3; j++) begin
      quo[NS][j] <= quo[NS-1][j] + QW'(rnd[j]);
    end
  end

  // output stage: saturate, restore sign, fit the field, zero the vectors of a flagged result
  localparam logic [QW-1:0] Lim = QW'(1) << FRAC_BITS;
  logic [2:0][QW-1:0]     qs;
  logic [2:0][63:0]       val;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qs[j]  = (quo[NS][j] > Lim) ? Lim : quo[NS][j];
      val[j] = ctl[NS].neg[j] ? 64'(0) - 64'(qs[j]) : 64'(qs[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl[NS].valid;
    end
    grav.bad_quat <= ctl[NS].bad;
    grav.grav_x   <= ctl[NS].bad ? '0 : val[0][OutWidth-1:0];
    grav.grav_y   <= ctl[NS].bad ? '0 : val[1][OutWidth-1:0];
    grav.grav_z   <= ctl[NS].bad ? '0 : val[2][OutWidth-1:0];
  end

endmodule

### hw/rtl/quaternion_projected_gravity.sv
// Top level: quaternion to body-frame projected gravity, fully pipelined.
// Depends on qpg_pkg, qpg_prod, qpg_div.
//
//  channel   ports            direction  transaction
//  input     start, busy,     in         accepted at clk edge with start & !busy
//            quat
//  result    done, grav       out        one cycle strobe on done, always taken
//
// The pipeline has two stages of products and sums, FRAC_BITS + 1 restoring
// divide stages (one quotient bit each, three lanes side by side), one rounding
// stage and one output register.
// A new quaternion is taken in every cycle; busy is held low.
// Synchronous reset clears only the valid bits; data registers are not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module quaternion_projected_gravity #(
  parameter int FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  qpg_pkg::quat_in_t   quat,
  output logic                done,
  output qpg_pkg::grav_out_t  grav
);
  import qpg_pkg::*;

  localparam int Latency = FRAC_BITS + 5;

  lane_ctl_t                ctl;
  logic [SumWidth-1:0]      sum_sq;
  logic [2:0][SumWidth-1:0] mag;

  // never stalls: one quaternion per cycle
  assign busy = 1'b0;

  // products, sum of squares and numerator magnitudes
  qpg_prod u_prod (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .quat     (quat),
    .ctl      (ctl),
    .sum_sq   (sum_sq),
    .mag      (mag)
  );

  // bit-per-stage division, rounding, saturation
  qpg_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl),
    .sum_sq    (sum_sq),
    .mag       (mag),
    .out_valid (done),
    .grav      (grav)
  );

  // each result comes from an earlier accepted transaction
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Latency))
    else $error("result without matching transaction");

  // an all-zero quaternion comes out flagged
  a_zero_flag : assert property (@(posedge clk) disable iff (rst)
    (start && quat == '0) |-> ##Latency (done && grav.bad_quat))
    else $error("zero quaternion not flagged");

  // a flagged result carries zero vectors
  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    (done && grav.bad_quat) |-> (grav.grav_x == '0 && grav.grav_y == '0
                                 && grav.grav_z == '0))
    else $error("flagged result has nonzero gravity");

endmodule

### sim/tb_quaternion_projected_gravity.sv
// Testbench for quaternion_projected_gravity: random and directed quaternions,
// results checked against a built-in integer predictor. Depends on qpg_pkg and quaternion_projected_gravity.
`timescale 1ns / 100ps

module tb_quaternion_projected_gravity;
  import qpg_pkg::*;

  localparam int FracBits  = 14;
  localparam int Latency   = FracBits + 5;
  localparam int WatchLim  = 2000;
  localparam int NumRandom = 1030;

  // scoreboard: predicts gravity for each accepted quaternion, checks results
  class gravity_board;
    grav_out_t pending[$];
    int errors;

    // round(|num| * 2^F / s) with ties away from zero, saturated, sign restored
    function automatic logic signed [15:0] quot(longint signed num, longint signed s);
      logic [127:0] mag, q, r;
      logic signed [15:0] res;
      mag = (num < 0) ? -num : num;
      q = (mag << FracBits) / s;
      r = (mag << FracBits) % s;
      if (2 * r >= s) q = q + 1;
      if (q > (128'd1 << FracBits)) q = 128'd1 << FracBits;
      res = q[15:0];
      return (num < 0) ? -res : res;
    endfunction

    function void note_quat(quat_in_t qi);
      longint signed w, x, y, z, s;
      grav_out_t g;
      w = qi.quat_w; x = qi.quat_x; y = qi.quat_y; z = qi.quat_z;
      s = w*w + x*x + y*y + z*z;
      g = '0;
      if (s == 0) begin
        g.bad_quat = 1'b1;
      end else begin
        g.grav_x = quot(2 * (w*y - x*z), s);
        g.grav_y = quot(-2 * (w*x + y*z), s);
        g.grav_z = quot(x*x + y*y - w*w - z*z, s);
      end
      pending = {pending, g};
    endfunction

    function void check_grav(grav_out_t got);
      grav_out_t exp_g;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_g = pending.pop_front();
      if (got !== exp_g) begin
        $display("%0t: mismatch expected x=%0d y=%0d z=%0d bad=%b,",
                 $time, exp_g.grav_x, exp_g.grav_y, exp_g.grav_z, exp_g.bad_quat);
        $display("    got x=%0d y=%0d z=%0d bad=%b",
                 got.grav_x, got.grav_y, got.grav_z, got.bad_quat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  quat_in_t quat = '0;
  grav_out_t grav;
  gravity_board board = new();
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_projected_gravity #(.FRAC_BITS(FracBits)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat(quat), .done(done), .grav(grav)
  );

  // sample both channels at the rising edge; watchdog counts quiet cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_quat(quat);
      if (done) board.check_grav(grav);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLim) begin
        $display("tb_quaternion_projected_gravity: errors");
        $finish;
      end
    end
  end

  // mostly no gap, so long runs with none; some short gaps and a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // one transaction: present at falling edge, hold until taken
  task automatic send_quat(logic [23:0] w, logic [23:0] x, logic [23:0] y, logic [23:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
    quat <= {w, x, y, z};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // random component: full range, small, or near extremes
  function automatic logic [23:0] rand_comp();
    unique case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 15) - 8);
      2: return 24'(32'h7FFFFF - $urandom_range(0, 3));
      default: return 24'(32'h800000 + $urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    logic [23:0] mx, mn;
    mx = 24'h7FFFFF;
    mn = 24'h800000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: zero quaternion, identity, axis turns, extremes, mixed signs
    send_quat(0, 0, 0, 0);
    send_quat(1, 0, 0, 0);
    send_quat(0, 1, 0, 0);
    send_quat(0, 0, 1, 0);
    send_quat(0, 0, 0, 1);
    send_quat(mx, 0, 0, 0);
    send_quat(mn, 0, 0, 0);
    send_quat(mx, mx, mx, mx);
    send_quat(mn, mn, mn, mn);
    send_quat(mx, mn, mx, mn);
    send_quat(mn, mx, mn, mx);
    send_quat(mx, mx, 0, 0);
    send_quat(mx, mn, 0, 0);
    send_quat(0, 0, mn, mx);
    send_quat(mn, 0, mn, 0);
    send_quat(24'hFFFFFF, 0, 0, 0);
    send_quat(1, 1, 1, 1);
    send_quat(3, 1, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(24'hFFFFFF, 1, 24'hFFFFFF, 1);
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 49) == 0) send_quat(0, 0, 0, 0);
      else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_quaternion_projected_gravity: clean");
    end else begin
      $display("tb_quaternion_projected_gravity: errors");
    end
    $finish;
  end

endmodule

### quaternion_projected_gravity.f
hw/rtl/qpg_pkg.sv
hw/rtl/qpg_prod.sv
hw/rtl/qpg_div.sv
hw/rtl/quaternion_projected_gravity.sv
sim/tb_quaternion_projected_gravity.sv
